### rtl/dual_wheel_incremental_pid_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dual-wheel incremental PID unit
// Both macros clock on aclk and are disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef DUAL_WHEEL_INCREMENTAL_PID_UNIT_ASSERT_SVH
`define DUAL_WHEEL_INCREMENTAL_PID_UNIT_ASSERT_SVH

// Same-cycle implication
`define DWIP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("dwip assertion failed");

// Next-cycle implication
`define DWIP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("dwip assertion failed");

`endif

### rtl/dwip_pkg.sv
// ----------------------------------------------------------------------------
// dwip_pkg
// Shared constants and types of the dual-wheel incremental PID unit.
// ----------------------------------------------------------------------------
package dwip_pkg;

    localparam int GAIN_FRAC_BITS = 8;
    localparam int WHEELS         = 2;

    localparam int GAIN_W   = 16;
    localparam int LIMIT_W  = 15;
    localparam int SPEED_W  = 15;
    localparam int ERR_W    = 16;
    localparam int DRIVE_W  = 16;
    localparam int WHEEL_W  = 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam int S_TDATA_W = 32;   // target, measured, padded to bytes
    localparam int M_TDATA_W = 32;   // drive, speed_error

    // Product and sum widths of the increment datapath
    localparam int GAIN_S_W = GAIN_W + 1;       // gain with a zero sign bit
    localparam int DP_W     = ERR_W + 1;        // e - e1
    localparam int DD_W     = ERR_W + 2;        // e - 2*e1 + e2
    localparam int PP_W     = GAIN_S_W + DP_W;
    localparam int PI_W     = GAIN_S_W + ERR_W;
    localparam int PD_W     = GAIN_S_W + DD_W;
    localparam int SUM_W    = PD_W + 1;
    localparam int ACC_W    = SUM_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP_LEFT     = 3'd0,
        REG_KI_LEFT     = 3'd1,
        REG_KD_LEFT     = 3'd2,
        REG_KP_RIGHT    = 3'd3,
        REG_KI_RIGHT    = 3'd4,
        REG_KD_RIGHT    = 3'd5,
        REG_DRIVE_LIMIT = 3'd6
    } cfg_reg_t;

    localparam logic [GAIN_W-1:0]  KP_RESET    = 16'd20480;
    localparam logic [GAIN_W-1:0]  KI_RESET    = 16'd5120;
    localparam logic [GAIN_W-1:0]  KD_RESET    = 16'd1280;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd6666;

    // Most negative drive and error code; never produced
    localparam logic [DRIVE_W-1:0] DRIVE_NEG_FULL = 16'h8000;

endpackage

### rtl/dual_wheel_incremental_pid_unit.sv
// ----------------------------------------------------------------------------
// dual_wheel_incremental_pid_unit
// Velocity-form PID speed loop for two wheels with saturated drive output.
// ----------------------------------------------------------------------------
//  channel | direction | tdata (low bit up)                 | tuser
//  s_      | in        | target_speed[14:0], measured[14:0] | wheel
//  m_      | out       | drive[15:0], speed_error[15:0]     | wheel_out
//  cfg_    | in        | write only: cfg_addr, cfg_wdata    | -
//
// One item per cycle while the m_ side accepts results; m_tvalid rises once the
// input transfer has passed the input register and then the result register.
// Input register, one combinational pass (three products, sum, rounding,
// saturation), result register.
// The per-wheel state is read and rewritten in that same pass, so a following
// item on the same wheel sees it at once. Reset (aresetn low, synchronous)
// clears state and restores the default gains and limit. A stalled m_ side
// holds the result and, one item later, stops s_tready.
// ----------------------------------------------------------------------------
module dual_wheel_incremental_pid_unit
    import dwip_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // target_speed[14:0], measured_speed[29:15], zero pad
    input  logic [WHEEL_W-1:0]    s_tuser,   // wheel

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // drive[15:0], speed_error[31:16]
    output logic [WHEEL_W-1:0]    m_tuser,   // wheel_out

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Configuration registers
    logic [GAIN_W-1:0]  kp_left_reg, ki_left_reg, kd_left_reg;
    logic [GAIN_W-1:0]  kp_right_reg, ki_right_reg, kd_right_reg;
    logic [LIMIT_W-1:0] limit_reg;

    // Input stage
    logic                      in_valid_reg;
    logic [WHEEL_W-1:0]        in_wheel_reg;
    logic signed [SPEED_W-1:0] in_target_reg;
    logic signed [SPEED_W-1:0] in_meas_reg;

    // Per-wheel loop state
    logic signed [DRIVE_W-1:0] drive_reg     [WHEELS];
    logic signed [ERR_W-1:0]   last_err_reg  [WHEELS];
    logic signed [ERR_W-1:0]   prev_err_reg  [WHEELS];

    // Output stage
    logic                      out_valid_reg;
    logic [WHEEL_W-1:0]        out_wheel_reg;
    logic signed [DRIVE_W-1:0] out_drive_reg;
    logic signed [ERR_W-1:0]   out_err_reg;

    logic advance;
    logic in_fire;

    // Datapath
    logic signed [ERR_W-1:0]    err;
    logic signed [ERR_W-1:0]    e1, e2;
    logic signed [DRIVE_W-1:0]  drive_old;
    logic [GAIN_W-1:0]          kp, ki, kd;
    logic signed [GAIN_S_W-1:0] kp_s, ki_s, kd_s;
    logic signed [DP_W-1:0]     d_p;
    logic signed [DD_W-1:0]     d_d;
    logic signed [PP_W-1:0]     prod_p;
    logic signed [PI_W-1:0]     prod_i;
    logic signed [PD_W-1:0]     prod_d;
    logic signed [SUM_W-1:0]    sum;
    logic signed [SUM_W-1:0]    frac_mask;
    logic                       round_up;
    logic signed [SUM_W-1:0]    inc;
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    lim_pos, lim_neg;
    logic signed [DRIVE_W-1:0]  drive_next;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign in_fire  = s_tvalid && s_tready;

    always_comb begin
        err = ERR_W'(in_target_reg) - ERR_W'(in_meas_reg);
        e1        = last_err_reg[in_wheel_reg];
        e2        = prev_err_reg[in_wheel_reg];
        drive_old = drive_reg[in_wheel_reg];

        if (in_wheel_reg == '0) begin
            kp = kp_left_reg;
            ki = ki_left_reg;
            kd = kd_left_reg;
        end else begin
            kp = kp_right_reg;
            ki = ki_right_reg;
            kd = kd_right_reg;
        end
        kp_s = signed'({1'b0, kp});
        ki_s = signed'({1'b0, ki});
        kd_s = signed'({1'b0, kd});

        d_p = DP_W'(err) - DP_W'(e1);
        d_d = DD_W'(err) - (DD_W'(e1) <<< 1) + DD_W'(e2);

        prod_p = PP_W'(kp_s) * PP_W'(d_p);
        prod_i = PI_W'(ki_s) * PI_W'(err);
        prod_d = PD_W'(kd_s) * PD_W'(d_d);

        sum = SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);

        // Scale down, truncating toward zero
        frac_mask = SUM_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);
        round_up  = sum[SUM_W-1] && ((sum & frac_mask) != '0);
        inc       = (sum >>> GAIN_FRAC_BITS) + signed'(SUM_W'(round_up));

        acc     = ACC_W'(drive_old) + ACC_W'(inc);
        lim_pos = signed'(ACC_W'(limit_reg));
        lim_neg = -lim_pos;
        if (acc > lim_pos) begin
            drive_next = DRIVE_W'(lim_pos);
        end else if (acc < lim_neg) begin
            drive_next = DRIVE_W'(lim_neg);
        end else begin
            drive_next = DRIVE_W'(acc);
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_left_reg  <= KP_RESET;
            ki_left_reg  <= KI_RESET;
            kd_left_reg  <= KD_RESET;
            kp_right_reg <= KP_RESET;
            ki_right_reg <= KI_RESET;
            kd_right_reg <= KD_RESET;
            limit_reg    <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                REG_KP_LEFT:     kp_left_reg  <= cfg_wdata;
                REG_KI_LEFT:     ki_left_reg  <= cfg_wdata;
                REG_KD_LEFT:     kd_left_reg  <= cfg_wdata;
                REG_KP_RIGHT:    kp_right_reg <= cfg_wdata;
                REG_KI_RIGHT:    ki_right_reg <= cfg_wdata;
                REG_KD_RIGHT:    kd_right_reg <= cfg_wdata;
                REG_DRIVE_LIMIT: limit_reg    <= cfg_wdata[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_fire) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            in_wheel_reg  <= s_tuser;
            in_target_reg <= signed'(s_tdata[SPEED_W-1:0]);
            in_meas_reg   <= signed'(s_tdata[2*SPEED_W-1:SPEED_W]);
        end
    end

    // Loop state: read-modify-write in the same pass as the result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WHEELS; i++) begin
                drive_reg[i]    <= '0;
                last_err_reg[i] <= '0;
                prev_err_reg[i] <= '0;
            end
        end else if (advance && in_valid_reg) begin
            drive_reg[in_wheel_reg]    <= drive_next;
            last_err_reg[in_wheel_reg] <= err;
            prev_err_reg[in_wheel_reg] <= e1;
        end
    end

    // Output stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            out_wheel_reg <= in_wheel_reg;
            out_drive_reg <= drive_next;
            out_err_reg   <= err;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_wheel_reg;
    assign m_tdata  = {out_err_reg, out_drive_reg};

endmodule

### rtl/dwip_checker.sv
// ----------------------------------------------------------------------------
// dwip_checker
// Port-level checks of the dual-wheel incremental PID unit, bound to the top.
// ----------------------------------------------------------------------------
`include "dual_wheel_incremental_pid_unit_assert.svh"

module dwip_checker
    import dwip_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata,   // drive, speed_error
    input logic [WHEEL_W-1:0]    m_tuser    // wheel_out
);

    logic s_xfer;
    logic m_stall;

    assign s_xfer  = s_tvalid && s_tready;
    assign m_stall = m_tvalid && !m_tready;

    // A stalled result holds
    `DWIP_ASSERT_NXT(a_m_hold, m_stall, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // Every input transfer is followed by a result waiting on m_, behind the input and result registers
    `DWIP_ASSERT_NXT(a_result_follows, s_xfer, ##1 m_tvalid)

    // Saturated drive never reaches the most negative code
    `DWIP_ASSERT_IMP(a_drive_range, m_tvalid, m_tdata[DRIVE_W-1:0] != DRIVE_NEG_FULL)

    // Difference of two 15-bit speeds stays symmetric
    `DWIP_ASSERT_IMP(a_error_range, m_tvalid, m_tdata[M_TDATA_W-1:DRIVE_W] != DRIVE_NEG_FULL)

endmodule

bind dual_wheel_incremental_pid_unit dwip_checker u_dwip_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### tb/dwip_drive_checker.sv
// ----------------------------------------------------------------------------
// dwip_drive_checker
// Watches the config port and both stream channels of the dual-wheel PID unit,
// keeps its own copy of gains, limit and per-wheel loop state, predicts the
// drive update of every input transfer and compares it with the result stream.
// ----------------------------------------------------------------------------
module dwip_drive_checker
    import dwip_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // target_speed[14:0], measured_speed[29:15]
    input  logic [WHEEL_W-1:0]    s_tuser,   // wheel

    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,   // drive[15:0], speed_error[31:16]
    input  logic [WHEEL_W-1:0]    m_tuser,   // wheel_out

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    output int                    mismatches,
    output int                    outstanding
);

    localparam int LEFT  = 0;
    localparam int RIGHT = 1;

    typedef struct packed {
        logic [WHEEL_W-1:0]        wheel;
        logic signed [DRIVE_W-1:0] drive;
        logic signed [ERR_W-1:0]   speed_error;
    } drive_update_t;

    logic [GAIN_W-1:0]         kp_gain [WHEELS];
    logic [GAIN_W-1:0]         ki_gain [WHEELS];
    logic [GAIN_W-1:0]         kd_gain [WHEELS];
    logic [LIMIT_W-1:0]        drive_bound;

    logic signed [DRIVE_W-1:0] drive_kept [WHEELS];
    logic signed [ERR_W-1:0]   err_last   [WHEELS];
    logic signed [ERR_W-1:0]   err_prev   [WHEELS];

    drive_update_t             drive_q [$];
    int                        err_count = 0;

    // One velocity-form PID update; advances the wheel's drive and error history
    function automatic drive_update_t next_drive(input logic [WHEEL_W-1:0] w,
                                                 input logic signed [SPEED_W-1:0] tgt,
                                                 input logic signed [SPEED_W-1:0] meas);
        int            e;
        int            e1;
        int            e2;
        longint        sum;
        longint        inc;
        longint        acc;
        longint        bound;
        drive_update_t r;
        e     = int'(tgt) - int'(meas);
        e1    = err_last[w];
        e2    = err_prev[w];
        sum   = longint'(kp_gain[w]) * (e - e1)
              + longint'(ki_gain[w]) * e
              + longint'(kd_gain[w]) * (e - 2 * e1 + e2);
        inc   = sum / (longint'(1) <<< GAIN_FRAC_BITS);   // truncates toward zero
        acc   = longint'(drive_kept[w]) + inc;
        bound = longint'(drive_bound);
        if (acc > bound)
            acc = bound;
        if (acc < -bound)
            acc = -bound;
        drive_kept[w]   = acc[DRIVE_W-1:0];
        err_prev[w]     = e1[ERR_W-1:0];
        err_last[w]     = e[ERR_W-1:0];
        r.wheel         = w;
        r.drive         = acc[DRIVE_W-1:0];
        r.speed_error   = e[ERR_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        drive_update_t got;
        drive_update_t want;
        if (!aresetn) begin
            kp_gain[LEFT]  = KP_RESET;
            ki_gain[LEFT]  = KI_RESET;
            kd_gain[LEFT]  = KD_RESET;
            kp_gain[RIGHT] = KP_RESET;
            ki_gain[RIGHT] = KI_RESET;
            kd_gain[RIGHT] = KD_RESET;
            drive_bound    = LIMIT_RESET;
            for (int i = 0; i < WHEELS; i++) begin
                drive_kept[i] = '0;
                err_last[i]   = '0;
                err_prev[i]   = '0;
            end
            drive_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_KP_LEFT:     kp_gain[LEFT]  = cfg_wdata;
                    REG_KI_LEFT:     ki_gain[LEFT]  = cfg_wdata;
                    REG_KD_LEFT:     kd_gain[LEFT]  = cfg_wdata;
                    REG_KP_RIGHT:    kp_gain[RIGHT] = cfg_wdata;
                    REG_KI_RIGHT:    ki_gain[RIGHT] = cfg_wdata;
                    REG_KD_RIGHT:    kd_gain[RIGHT] = cfg_wdata;
                    REG_DRIVE_LIMIT: drive_bound    = cfg_wdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.wheel       = m_tuser;
                got.drive       = m_tdata[DRIVE_W-1:0];
                got.speed_error = m_tdata[DRIVE_W+ERR_W-1:DRIVE_W];
                if (drive_q.size() == 0) begin
                    err_count++;
                    $display("%0t unexpected result transfer: wheel %0d drive %0d error %0d",
                             $time, got.wheel, got.drive, got.speed_error);
                end else begin
                    want = drive_q.pop_front();
                    if (got.wheel !== want.wheel) begin
                        err_count++;
                        $display("%0t wheel mismatch: expected %0d, got %0d",
                                 $time, want.wheel, got.wheel);
                    end
                    if (got.drive !== want.drive) begin
                        err_count++;
                        $display("%0t drive mismatch (wheel %0d): expected %0d, got %0d",
                                 $time, want.wheel, want.drive, got.drive);
                    end
                    if (got.speed_error !== want.speed_error) begin
                        err_count++;
                        $display("%0t speed error mismatch (wheel %0d): expected %0d, got %0d",
                                 $time, want.wheel, want.speed_error, got.speed_error);
                    end
                end
            end
            if (s_tvalid && s_tready)
                drive_q.push_back(next_drive(s_tuser, s_tdata[SPEED_W-1:0],
                                             s_tdata[2*SPEED_W-1:SPEED_W]));
        end
        mismatches  <= err_count;
        outstanding <= drive_q.size();
    end

endmodule

### tb/dual_wheel_incremental_pid_unit_tb.sv
// ----------------------------------------------------------------------------
// dual_wheel_incremental_pid_unit_tb
// Drives speed samples and gain/limit settings into the dual-wheel PID unit
// with random gaps on the input and random stalls on the output; the checker
// beside the unit predicts every drive update and counts mismatches.
// ----------------------------------------------------------------------------
module dual_wheel_incremental_pid_unit_tb;
    import dwip_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;   // past the register list
    localparam int SPEED_MAX     = 16383;
    localparam int SPEED_MIN     = -16384;
    localparam int SETS_PER_MODE = 6;
    localparam int ITEMS_PER_SET = 78;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // target_speed[14:0], measured_speed[29:15]
    logic [WHEEL_W-1:0]    s_tuser   = '0;   // wheel
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;          // drive[15:0], speed_error[31:16]
    logic [WHEEL_W-1:0]    m_tuser;          // wheel_out
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int mismatches;
    int outstanding;
    int tx_idle_pct   = 7;
    int rx_idle_pct   = 72;
    int items_sent    = 0;
    int settings_done = 0;

    always #6 aclk = ~aclk;

    dual_wheel_incremental_pid_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    dwip_drive_checker drive_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic send_sample(input logic [WHEEL_W-1:0] w,
                               input logic signed [SPEED_W-1:0] tgt,
                               input logic signed [SPEED_W-1:0] meas);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= w;
        s_tdata  <= {2'b00, meas, tgt};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // Stop sending and wait until every predicted update has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic apply_cfg(input logic [GAIN_W-1:0] kp_l, input logic [GAIN_W-1:0] ki_l,
                             input logic [GAIN_W-1:0] kd_l, input logic [GAIN_W-1:0] kp_r,
                             input logic [GAIN_W-1:0] ki_r, input logic [GAIN_W-1:0] kd_r,
                             input logic [LIMIT_W-1:0] lim);
        put_reg(REG_KP_LEFT, kp_l);
        put_reg(REG_KI_LEFT, ki_l);
        put_reg(REG_KD_LEFT, kd_l);
        put_reg(REG_KP_RIGHT, kp_r);
        put_reg(REG_KI_RIGHT, ki_r);
        put_reg(REG_KD_RIGHT, kd_r);
        // top data bit is not part of the limit
        put_reg(REG_DRIVE_LIMIT, {1'($urandom_range(1)), lim});
        cfg_wr_en <= 1'b0;
        settings_done++;
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            2:       return GAIN_W'($urandom_range(1024));
            default: return GAIN_W'($urandom_range(65535));
        endcase
    endfunction

    function automatic logic [LIMIT_W-1:0] pick_limit();
        case ($urandom_range(4))
            0:       return '0;
            1:       return '1;
            2:       return LIMIT_W'($urandom_range(200));
            default: return LIMIT_W'($urandom_range(32767));
        endcase
    endfunction

    initial begin
        int goal [WHEELS];
        int tgt;
        int meas;
        logic [WHEEL_W-1:0] w;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset gains and limit: full-scale errors both ways, saturation at the default
        send_sample(1'b0, SPEED_W'(SPEED_MAX), SPEED_W'(SPEED_MIN));
        send_sample(1'b1, SPEED_W'(SPEED_MIN), SPEED_W'(SPEED_MAX));
        send_sample(1'b0, SPEED_W'(SPEED_MIN), SPEED_W'(SPEED_MAX));
        send_sample(1'b1, 0, 0);
        send_sample(1'b0, 1, 2);
        send_sample(1'b1, -3, 4);
        drain();

        // Maximum gains and limit: drive both wheels to full scale
        apply_cfg('1, '1, '1, '1, '1, '1, '1);
        send_sample(1'b0, SPEED_W'(SPEED_MAX), SPEED_W'(SPEED_MIN));
        send_sample(1'b1, SPEED_W'(SPEED_MAX), SPEED_W'(SPEED_MIN));
        send_sample(1'b0, SPEED_W'(SPEED_MAX), SPEED_W'(SPEED_MIN));
        send_sample(1'b1, SPEED_W'(SPEED_MAX), SPEED_W'(SPEED_MIN));
        drain();

        // Lowered limit, zero gains: kept drive is clipped on the next update
        put_reg(REG_UNUSED, '1);
        apply_cfg('0, '0, '0, '0, '0, '0, 15'd100);
        send_sample(1'b1, 5, 5);
        send_sample(1'b0, -7, 9);
        drain();

        // Zero limit forces the drive to zero
        apply_cfg(KP_RESET, KI_RESET, KD_RESET, KP_RESET, KI_RESET, KD_RESET, '0);
        send_sample(1'b0, 300, -200);
        send_sample(1'b1, -1000, 50);
        send_sample(1'b0, SPEED_W'(SPEED_MIN), SPEED_W'(SPEED_MAX));
        drain();

        // Tiny gains: fractional increments of both signs are truncated toward zero
        apply_cfg(16'd1, 16'd3, 16'd0, 16'd2, 16'd1, 16'd5, '1);
        send_sample(1'b0, -100, 0);
        send_sample(1'b0, -260, 3);
        send_sample(1'b1, 97, 0);
        send_sample(1'b1, -33, 40);
        send_sample(1'b0, 500, -2);
        drain();

        for (int mode = 0; mode < 3; mode++) begin
            tx_idle_pct = (mode == 0) ? 7 : (mode == 1) ? 72 : 0;
            rx_idle_pct = (mode == 0) ? 72 : (mode == 1) ? 7 : 0;
            for (int set = 0; set < SETS_PER_MODE; set++) begin
                if (set == 0)
                    apply_cfg('1, '1, '1, '1, '1, '1, '1);
                else
                    apply_cfg(pick_gain(), pick_gain(), pick_gain(),
                              pick_gain(), pick_gain(), pick_gain(), pick_limit());
                for (int i = 0; i < WHEELS; i++)
                    goal[i] = $urandom_range(2000) - 1000;
                for (int n = 0; n < ITEMS_PER_SET; n++) begin
                    w = WHEEL_W'($urandom_range(1));
                    case ($urandom_range(9))
                        0: begin
                            tgt  = $urandom_range(32767) + SPEED_MIN;
                            meas = $urandom_range(32767) + SPEED_MIN;
                        end
                        1: begin
                            tgt  = $urandom_range(1) ? SPEED_MAX : SPEED_MIN;
                            meas = $urandom_range(1) ? SPEED_MAX : SPEED_MIN;
                        end
                        default: begin
                            // loop tracking a set point: measured close to target
                            if ($urandom_range(9) == 0)
                                goal[w] = $urandom_range(32767) + SPEED_MIN;
                            tgt  = goal[w];
                            meas = tgt + $urandom_range(64) - 32;
                            if (meas > SPEED_MAX)
                                meas = SPEED_MAX;
                            if (meas < SPEED_MIN)
                                meas = SPEED_MIN;
                        end
                    endcase
                    send_sample(w, SPEED_W'(tgt), SPEED_W'(meas));
                end
                drain();
            end
        end

        $display("Covered %0d speed updates on both wheels over %0d gain and limit settings,",
                 items_sent, settings_done);
        $display("with full-scale errors, zero and lowered limits, and stalls on either side.");
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #5000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/dwip_pkg.sv
rtl/dual_wheel_incremental_pid_unit.sv
rtl/dwip_checker.sv
tb/dwip_drive_checker.sv
tb/dual_wheel_incremental_pid_unit_tb.sv
